/* src/hsirgb_pkg.sv */
`default_nettype none
package hsirgb_pkg;

    localparam int RATIO_FRAC_BITS_DEF = 12;

    localparam int HUE_W      = 10;
    localparam int LEVEL_W    = 8;
    localparam int SAT_W      = 9;
    localparam int INT_W      = 10;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int SECTOR_W   = 2;
    localparam int OFFSET_W   = 7;

    localparam int FULL_DEG   = 360;
    localparam int SECTOR_DEG = 120;
    localparam int LEVEL_MAX  = 255;
    localparam int HALF_DEG   = 180;

    localparam logic [SAT_W-1:0]   SAT_MAX     = 9'd256;
    localparam logic [INT_W-1:0]   INT_MAX     = 10'd512;
    localparam logic [SCALE_W-1:0] LEVEL_SCALE = SCALE_W'(LEVEL_MAX / 3);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'((LEVEL_MAX / 3) * 256);

    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY  = 8'd1;

    localparam logic [SECTOR_W-1:0] SECTOR_RG = 2'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_GB = 2'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_BR = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
    } hsirgb_item_t;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } hsirgb_back_status_t;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cosine in q30, 0..90 degrees, taylor series
    function automatic logic signed [63:0] cos_quarter(input int unsigned deg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        x    = udiv64(64'(deg) * PI_Q30, 64'(HALF_DEG));
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        sum  = $signed(Q30_ONE);
        for (int k = 1; k <= 12; k++) begin
            term = udiv64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] cos_deg(input int d);
        int unsigned a;
        a = (d < 0) ? int'(-d) : d;
        if (a > 90) begin
            return -cos_quarter(HALF_DEG - a);
        end
        return cos_quarter(a);
    endfunction

    // cos(h)/cos(60-h) scaled by 2^frac, rounded half away from zero
    function automatic logic signed [31:0] ratio_entry(input int h, input int frac);
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        num = cos_deg(h);
        den = cos_deg(60 - h);
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q   = udiv64((mag << frac) + (64'(den) >> 1), 64'(den));
        return (num < 0) ? -$signed(32'(q)) : $signed(32'(q));
    endfunction

endpackage
`default_nettype wire

/* src/hsirgb_front.sv */
`default_nettype none
module hsirgb_front
    import hsirgb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [HUE_W-1:0]   s_hue,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hsirgb_item_t            out_item
);

    logic         valid_reg;
    hsirgb_item_t item_reg;
    hsirgb_item_t item_next;
    logic [HUE_W-1:0] hue_mod;

    // hue below 1024, so at most two subtractions of a full turn
    always_comb begin
        if (s_hue >= HUE_W'(2 * FULL_DEG)) begin
            hue_mod = s_hue - HUE_W'(2 * FULL_DEG);
        end else if (s_hue >= HUE_W'(FULL_DEG)) begin
            hue_mod = s_hue - HUE_W'(FULL_DEG);
        end else begin
            hue_mod = s_hue;
        end
    end

    always_comb begin
        if (hue_mod >= HUE_W'(2 * SECTOR_DEG)) begin
            item_next.sector = SECTOR_BR;
            item_next.offset = OFFSET_W'(hue_mod - HUE_W'(2 * SECTOR_DEG));
        end else if (hue_mod >= HUE_W'(SECTOR_DEG)) begin
            item_next.sector = SECTOR_GB;
            item_next.offset = OFFSET_W'(hue_mod - HUE_W'(SECTOR_DEG));
        end else begin
            item_next.sector = SECTOR_RG;
            item_next.offset = OFFSET_W'(hue_mod);
        end
    end

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

/* src/hsirgb_queue.sv */
`default_nettype none
module hsirgb_queue
    import hsirgb_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire hsirgb_item_t in_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output hsirgb_item_t      out_item
);

    hsirgb_item_t         mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

/* src/hsirgb_back.sv */
`default_nettype none
module hsirgb_back
    import hsirgb_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hsirgb_item_t         in_item,
    input  wire logic [SAT_W-1:0]     saturation,
    input  wire logic [SCALE_W-1:0]   level_scale,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [LEVEL_W-1:0]        m_red,
    output logic [LEVEL_W-1:0]        m_green,
    output logic [LEVEL_W-1:0]        m_blue,
    output hsirgb_back_status_t       status
);

    localparam int RW  = RATIO_FRAC_BITS + 3;
    localparam int FW  = RATIO_FRAC_BITS + 11;
    localparam int PW  = FW + SCALE_W + 1;
    localparam int SH  = 16 + RATIO_FRAC_BITS;
    localparam int LW  = SCALE_W + SAT_W;

    logic signed [RW-1:0] ratio_tab [SECTOR_DEG];

    for (genvar g = 0; g < SECTOR_DEG; g++) begin : g_tab
        localparam logic signed [31:0] ENTRY = ratio_entry(g, RATIO_FRAC_BITS);
        assign ratio_tab[g] = RW'(ENTRY);
    end

    logic                  v1_reg;
    logic [SECTOR_W-1:0]   sec1_reg;
    logic signed [FW-1:0]  fac_up1_reg;
    logic signed [FW-1:0]  fac_dn1_reg;
    logic                  v2_reg;
    logic [SECTOR_W-1:0]   sec2_reg;
    logic signed [PW-1:0]  prod_up2_reg;
    logic signed [PW-1:0]  prod_dn2_reg;
    logic [LW-1:0]         prod_low2_reg;
    logic                  m_valid_reg;
    logic [LEVEL_W-1:0]    red_reg;
    logic [LEVEL_W-1:0]    green_reg;
    logic [LEVEL_W-1:0]    blue_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic signed [RW-1:0]  ratio_up;
    logic signed [RW-1:0]  ratio_dn;
    logic signed [FW-1:0]  sat_ext;
    logic signed [FW-1:0]  fac_up_next;
    logic signed [FW-1:0]  fac_dn_next;
    logic signed [PW-1:0]  scale_ext;
    logic signed [PW-1:0]  prod_up_next;
    logic signed [PW-1:0]  prod_dn_next;
    logic [LW-1:0]         prod_low_next;
    logic [LEVEL_W-1:0]    lvl_up;
    logic [LEVEL_W-1:0]    lvl_dn;
    logic [LEVEL_W-1:0]    lvl_low;
    logic [LEVEL_W-1:0]    red_next;
    logic [LEVEL_W-1:0]    green_next;
    logic [LEVEL_W-1:0]    blue_next;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [PW-1:0] p);
        if (p[PW-1]) begin
            return '0;
        end else if (|p[PW-2:SH+LEVEL_W]) begin
            return LEVEL_W'(LEVEL_MAX);
        end
        return p[SH+LEVEL_W-1:SH];
    endfunction

    assign rdy3     = !m_valid_reg || m_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: table lookup and saturation blend
    assign ratio_up    = ratio_tab[in_item.offset];
    assign ratio_dn    = RW'(1 << RATIO_FRAC_BITS) - ratio_up;
    assign sat_ext     = FW'(saturation);
    assign fac_up_next = FW'(256 << RATIO_FRAC_BITS) + sat_ext * FW'(ratio_up);
    assign fac_dn_next = FW'(256 << RATIO_FRAC_BITS) + sat_ext * FW'(ratio_dn);

    // stage 2: scale by 85*intensity, the /3 of 255/3 cancels exactly
    assign scale_ext     = PW'(level_scale);
    assign prod_up_next  = PW'(fac_up1_reg) * scale_ext;
    assign prod_dn_next  = PW'(fac_dn1_reg) * scale_ext;
    assign prod_low_next = LW'(level_scale) * LW'(SAT_MAX - saturation);

    // stage 3: truncate, clamp and route by sector
    assign lvl_up  = clamp_level(prod_up2_reg);
    assign lvl_dn  = clamp_level(prod_dn2_reg);
    assign lvl_low = (|prod_low2_reg[LW-1:16+LEVEL_W]) ? LEVEL_W'(LEVEL_MAX)
                                                       : prod_low2_reg[16+LEVEL_W-1:16];

    always_comb begin
        case (sec2_reg)
            SECTOR_RG: begin
                red_next   = lvl_up;
                green_next = lvl_dn;
                blue_next  = lvl_low;
            end
            SECTOR_GB: begin
                red_next   = lvl_low;
                green_next = lvl_up;
                blue_next  = lvl_dn;
            end
            SECTOR_BR: begin
                red_next   = lvl_dn;
                green_next = lvl_low;
                blue_next  = lvl_up;
            end
            default: begin
                red_next   = lvl_dn;
                green_next = lvl_low;
                blue_next  = lvl_up;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            sec1_reg    <= in_item.sector;
            fac_up1_reg <= fac_up_next;
            fac_dn1_reg <= fac_dn_next;
        end
        if (rdy2 && v1_reg) begin
            sec2_reg      <= sec1_reg;
            prod_up2_reg  <= prod_up_next;
            prod_dn2_reg  <= prod_dn_next;
            prod_low2_reg <= prod_low_next;
        end
        if (rdy3 && v2_reg) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red           = red_reg;
    assign m_green         = green_reg;
    assign m_blue          = blue_reg;
    assign status.s1_valid = v1_reg;
    assign status.s2_valid = v2_reg;

endmodule
`default_nettype wire

/* src/hsi_to_rgb_converter.sv */
`default_nettype none
// throughput: one beat per cycle while m_ready does not stall the output, limited by the single-issue pipeline
// path: an accepted beat passes through the front register, the queue,
//   the blend multiply stage, the scale multiply stage and the output register
// the 4-entry queue lets the front keep accepting while the back stalls on m_ready
// reset: synchronous active-low aresetn clears valid flags and the queue, and sets
//   saturation and intensity to 1.0; no clearing pass
module hsi_to_rgb_converter
    import hsirgb_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [HUE_W-1:0]       s_hue,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [LEVEL_W-1:0]          m_red,
    output logic [LEVEL_W-1:0]          m_green,
    output logic [LEVEL_W-1:0]          m_blue,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    logic [SAT_W-1:0]    saturation_reg;
    logic [SAT_W-1:0]    saturation_next;
    logic [SCALE_W-1:0]  scale_reg;
    logic [SCALE_W-1:0]  scale_next;
    logic [INT_W-1:0]    intensity_clamped;

    logic                front_valid;
    logic                front_ready;
    hsirgb_item_t        front_item;
    logic                queue_valid;
    logic                queue_ready;
    hsirgb_item_t        queue_item;
    hsirgb_back_status_t back_status;

    // registers hold clamped values; intensity is kept premultiplied by 255/3
    assign saturation_next   = (cfg_wr_data[SAT_W-1:0] > SAT_MAX) ? SAT_MAX
                                                                  : cfg_wr_data[SAT_W-1:0];
    assign intensity_clamped = (cfg_wr_data[INT_W-1:0] > INT_MAX) ? INT_MAX
                                                                  : cfg_wr_data[INT_W-1:0];
    assign scale_next        = SCALE_W'(intensity_clamped) * LEVEL_SCALE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saturation_reg <= SAT_MAX;
            scale_reg      <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SATURATION: saturation_reg <= saturation_next;
                CFG_INTENSITY:  scale_reg      <= scale_next;
                default: begin
                end
            endcase
        end
    end

    hsirgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_hue     (s_hue),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    hsirgb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    hsirgb_back #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .saturation  (saturation_reg),
        .level_scale (scale_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .status      (back_status)
    );

    logic pipe_empty;
    assign pipe_empty = !front_valid && !queue_valid && !back_status.s1_valid
                        && !back_status.s2_valid && !m_valid;

`ifndef ASSERT_OFF
    // a beat into an empty pipeline comes out after the fixed latency
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && pipe_empty) |-> ##5 m_valid)
        else $error("result missing after fixed latency");

    // a taken result with nothing behind it leaves the output empty
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !front_valid && !queue_valid && !back_status.s1_valid
         && !back_status.s2_valid) |=> !m_valid)
        else $error("result produced with nothing in flight");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_hsi_to_rgb_converter.sv */
`timescale 1ns / 1ps

module tb_hsi_to_rgb_converter;
    import hsirgb_pkg::*;

    localparam int FRAC_BITS = RATIO_FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_TAIL = 8;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned PI_FX = 64'd3373259426;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    typedef struct {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [HUE_W-1:0]   src_hue;
    } color_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [HUE_W-1:0]      s_hue = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LEVEL_W-1:0]    m_red;
    logic [LEVEL_W-1:0]    m_green;
    logic [LEVEL_W-1:0]    m_blue;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    longint ratio_lut [SECTOR_DEG];
    logic [SAT_W-1:0] sat_model = SAT_MAX;
    logic [INT_W-1:0] int_model = 10'd256;
    color_t pending_colors [$];
    color_t want;

    int errors = 0;
    int hues_sent = 0;
    int colors_checked = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    int burst_left = 0;
    int burst_max = 0;
    int gap_max = 0;

    rx_mode_t rx_mode = RX_ALWAYS;
    int rx_ready_pct = 70;
    int rx_phase = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    hsi_to_rgb_converter #(
        .RATIO_FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_hue(s_hue),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_red(m_red),
        .m_green(m_green),
        .m_blue(m_blue),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // cosine in q30 for |deg| up to 180
    function automatic longint cosine_q30(input int deg);
        longint unsigned a;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        bit neg;
        a = (deg < 0) ? longint'(-deg) : longint'(deg);
        neg = (a > 90);
        if (neg) begin
            a = HALF_DEG - a;
        end
        x = a * PI_FX / HALF_DEG;
        x2 = (x * x) >> 30;
        term = ONE_Q30;
        sum = longint'(ONE_Q30);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return neg ? -sum : sum;
    endfunction

    // base * (256*one + s*r) scaled down, truncated and clamped
    function automatic logic [LEVEL_W-1:0] level_of(input longint s, input longint i,
                                                     input longint r);
        longint one;
        longint prod;
        longint v;
        one = longint'(1) << FRAC_BITS;
        prod = LEVEL_MAX * i * (256 * one + s * r);
        if (prod <= 0) begin
            return '0;
        end
        v = prod / (3 * 65536 * one);
        return (v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(v);
    endfunction

    function automatic color_t predict_color(input logic [HUE_W-1:0] hue);
        int unsigned h;
        int unsigned sector;
        int unsigned off;
        longint s;
        longint i;
        longint one;
        longint r;
        longint low_v;
        logic [LEVEL_W-1:0] up;
        logic [LEVEL_W-1:0] down;
        logic [LEVEL_W-1:0] low;
        color_t c;
        h = hue % FULL_DEG;
        sector = h / SECTOR_DEG;
        off = h % SECTOR_DEG;
        s = (sat_model > SAT_MAX) ? longint'(SAT_MAX) : longint'(sat_model);
        i = (int_model > INT_MAX) ? longint'(INT_MAX) : longint'(int_model);
        one = longint'(1) << FRAC_BITS;
        r = ratio_lut[off];
        up = level_of(s, i, r);
        down = level_of(s, i, one - r);
        low_v = LEVEL_MAX * i * (256 - s) / (3 * 65536);
        low = (low_v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(low_v);
        c.src_hue = hue;
        case (sector)
            SECTOR_RG: begin
                c.red = up;
                c.green = down;
                c.blue = low;
            end
            SECTOR_GB: begin
                c.red = low;
                c.green = up;
                c.blue = down;
            end
            default: begin
                c.red = down;
                c.green = low;
                c.blue = up;
            end
        endcase
        return c;
    endfunction

    // input side: predict on every accepted beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_colors.push_back(predict_color(s_hue));
        end
    end

    // output side: compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_colors.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, actual r=%0d g=%0d b=%0d",
                         $time, m_red, m_green, m_blue);
            end else begin
                want = pending_colors.pop_front();
                colors_checked++;
                if ({m_red, m_green, m_blue} !== {want.red, want.green, want.blue}) begin
                    errors++;
                    $display("%0t: hue %0d expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                             $time, want.src_hue, want.red, want.green, want.blue,
                             m_red, m_green, m_blue);
                end
            end
        end
    end

    // receiver stall patterns and the long hold-off
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 99) < rx_ready_pct);
                default: begin
                    rx_phase = (rx_phase + 1) % 7;
                    m_ready <= (rx_phase >= 3);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_colors.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_hue(input logic [HUE_W-1:0] hue);
        s_valid <= 1'b1;
        s_hue <= hue;
        do @(posedge aclk); while (!s_ready);
        hues_sent++;
        if (gap_max == 0 || burst_left > 0) begin
            if (burst_left > 0) begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    task automatic drain_colors();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_colors.size() != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SATURATION) begin
            sat_model = data[SAT_W-1:0];
        end else if (idx == CFG_INTENSITY) begin
            int_model = data[INT_W-1:0];
        end
        @(posedge aclk);
    endtask

    task automatic set_color_regs(input logic [CFG_DATA_W-1:0] sat,
                                  input logic [CFG_DATA_W-1:0] inten);
        drain_colors();
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_INTENSITY, inten);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        logic [HUE_W-1:0] hues [10];
        hues = '{10'd0, 10'd1, 10'd59, 10'd60, 10'd119, 10'd120, 10'd240, 10'd359,
                 10'd360, 10'd1023};
        foreach (hues[k]) begin
            send_hue(hues[k]);
        end
    endtask

    task automatic test_register_extremes();
        set_color_regs(10'd0, 10'd0);
        send_hue(10'd0);
        send_hue(10'd200);
        // full saturation and double intensity: zero and clamped channels
        set_color_regs(10'd256, 10'd512);
        send_hue(10'd0);
        send_hue(10'd119);
        send_hue(10'd300);
        // above range on both registers
        set_color_regs(10'd511, 10'd1023);
        send_hue(10'd60);
        send_hue(10'd240);
        // bit above the saturation width is dropped
        set_color_regs(10'h200, 10'd384);
        send_hue(10'd45);
    endtask

    task automatic test_ignored_index();
        drain_colors();
        write_reg(CFG_IDX_W'(2), 10'd0);
        write_reg({CFG_IDX_W{1'b1}}, 10'h3FF);
        send_hue(10'd90);
        send_hue(10'd700);
    endtask

    task automatic test_backpressure();
        set_color_regs(10'd128, 10'd300);
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) begin
            send_hue(HUE_W'($urandom_range(0, 1023)));
        end
        drain_colors();
    endtask

    task automatic test_random_stream();
        logic [CFG_DATA_W-1:0] sat_pick;
        logic [CFG_DATA_W-1:0] int_pick;
        logic [HUE_W-1:0] hue;
        for (int p = 0; p < 6; p++) begin
            case (p % 3)
                0: begin
                    sat_pick = CFG_DATA_W'($urandom_range(0, 1023));
                    int_pick = CFG_DATA_W'($urandom_range(0, 1023));
                end
                1: begin
                    sat_pick = (p == 1) ? 10'd0 : 10'd511;
                    int_pick = (p == 1) ? 10'd1023 : 10'd512;
                end
                default: begin
                    sat_pick = CFG_DATA_W'($urandom_range(200, 300));
                    int_pick = CFG_DATA_W'($urandom_range(400, 600));
                end
            endcase
            set_color_regs(sat_pick, int_pick);
            rx_mode = rx_mode_t'(p % 3);
            rx_ready_pct = $urandom_range(30, 90);
            gap_max = (p == 0) ? 0 : $urandom_range(2, 12);
            burst_max = $urandom_range(1, 20);
            burst_left = 0;
            for (int k = 0; k < 300; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    hue = HUE_W'($urandom_range(0, 7) * SECTOR_DEG
                                 + ($urandom_range(0, 1) ? 0 : SECTOR_DEG - 1));
                end else begin
                    hue = HUE_W'($urandom_range(0, 1023));
                end
                send_hue(hue);
            end
        end
    endtask

    initial begin
        longint num_q;
        longint den_q;
        longint unsigned mag;
        longint unsigned q;
        for (int h = 0; h < SECTOR_DEG; h++) begin
            num_q = cosine_q30(h);
            den_q = cosine_q30(60 - h);
            mag = (num_q < 0) ? longint'(-num_q) : longint'(num_q);
            q = ((mag << FRAC_BITS) + longint'(den_q) / 2) / longint'(den_q);
            ratio_lut[h] = (num_q < 0) ? -longint'(q) : longint'(q);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_ignored_index();
        test_backpressure();
        test_random_stream();

        drain_colors();
        if (pending_colors.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_colors.size());
        end
        $display("run covered %0d hue beats, %0d colors checked, %0d register settings",
                 hues_sent, colors_checked, settings_used);
        $display("with sector edges, register extremes, bursty input and receiver stalls");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
